[hw/rtl/cubic_bezier_forward_diff_raster_assert.svh]
// ----------------------------------------------------------------------------
// cubic bezier raster assertion macros
// shorthand for clocked checks on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_FORWARD_DIFF_RASTER_ASSERT_SVH
`define CUBIC_BEZIER_FORWARD_DIFF_RASTER_ASSERT_SVH

// same-cycle implication
`define CBFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cbfd check failed");

// next-cycle implication
`define CBFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cbfd check failed");

`endif

[hw/rtl/cbfd_pkg.sv]
// ----------------------------------------------------------------------------
// cbfd_pkg
// shared widths and constants of the cubic bezier forward difference raster
// ----------------------------------------------------------------------------
`default_nettype none

package cbfd_pkg;

    localparam int MAX_STEPS  = 64;
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    // differences and step size carry this many fraction bits
    localparam int Q_FRAC = 32;

    // square root: one result bit per cycle
    localparam int SQ_W       = 2 * COORD_BITS + 1;
    localparam int ROOT_STEPS = COORD_BITS + FRAC_BITS + 1;
    localparam int ROOT_W     = ROOT_STEPS;
    localparam int PAIR_W     = 2 * (COORD_BITS + 1);
    localparam int REM_W      = ROOT_W + 3;
    localparam int RCNT_W     = $clog2(ROOT_STEPS);

    // perimeter sum and clamped factor
    localparam int FACT_W  = ROOT_W + 2;
    localparam int STEP_W  = $clog2(MAX_STEPS);
    localparam int CLAMP_W = FRAC_BITS + STEP_W;
    localparam logic [CLAMP_W-1:0] FACT_CAP = CLAMP_W'(MAX_STEPS - 1) << FRAC_BITS;
    localparam logic [CLAMP_W-1:0] FACT_ONE = CLAMP_W'(1) << FRAC_BITS;

    // step size division
    localparam int NUM_W  = Q_FRAC + FRAC_BITS + 1;
    localparam int DLT_W  = Q_FRAC + 1;
    localparam int DCNT_W = $clog2(NUM_W);

    // shared multiplier: signed a operand, unsigned b operand
    localparam int LO_W   = 16;
    localparam int MA_W   = (COORD_BITS + 4 > DLT_W - LO_W + 1) ?
                            COORD_BITS + 4 : DLT_W - LO_W + 1;
    localparam int PROD_W = MA_W + DLT_W + 1;
    localparam int RND_W  = PROD_W + LO_W + 1;

    // walk registers
    localparam int D_W = 64;

    localparam int IN_TDATA_W  = ((8 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

[hw/rtl/cbfd_root.sv]
// ----------------------------------------------------------------------------
// cbfd_root
// digit-by-digit square root, floor(sqrt(radicand) * 2^FRAC_BITS), one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cbfd_root (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [cbfd_pkg::SQ_W-1:0]     radicand,
    output logic      [cbfd_pkg::ROOT_W-1:0]   root,
    output logic                               done
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [cbfd_pkg::RCNT_W-1:0]       cnt_reg;
    logic [cbfd_pkg::PAIR_W-1:0]       pair_reg;
    logic [cbfd_pkg::REM_W-1:0]        rem_reg;
    logic [cbfd_pkg::ROOT_W-1:0]       q_reg;

    logic                              int_part;
    logic [1:0]                        pair;
    logic [cbfd_pkg::REM_W-1:0]        rs;
    logic [cbfd_pkg::REM_W-1:0]        trial;
    logic                              ge;

    always_comb begin
        // only the integer digits carry radicand bits, fraction digits bring zeros
        int_part = (cnt_reg >= cbfd_pkg::RCNT_W'(cbfd_pkg::FRAC_BITS));
        pair     = int_part ? pair_reg[cbfd_pkg::PAIR_W-1 -: 2] : 2'b00;
        rs       = {rem_reg[cbfd_pkg::REM_W-3:0], pair};
        trial    = cbfd_pkg::REM_W'({q_reg, 2'b01});
        ge       = (rs >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= cbfd_pkg::RCNT_W'(cbfd_pkg::ROOT_STEPS - 1);
                pair_reg <= cbfd_pkg::PAIR_W'(radicand);
                rem_reg  <= '0;
                q_reg    <= '0;
            end else if (busy_reg) begin
                rem_reg <= ge ? (rs - trial) : rs;
                q_reg   <= {q_reg[cbfd_pkg::ROOT_W-2:0], ge};
                if (int_part) begin
                    pair_reg <= pair_reg << 2;
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = q_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

[hw/rtl/cbfd_div.sv]
// ----------------------------------------------------------------------------
// cbfd_div
// restoring divider, step size = round(2^(32+FRAC_BITS) / divisor), one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cbfd_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [cbfd_pkg::CLAMP_W-1:0]  divisor,
    output logic      [cbfd_pkg::DLT_W-1:0]    quotient,
    output logic                               done
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [cbfd_pkg::DCNT_W-1:0]       cnt_reg;
    logic [cbfd_pkg::NUM_W-1:0]        num_reg;
    logic [cbfd_pkg::CLAMP_W-1:0]      dvs_reg;
    logic [cbfd_pkg::CLAMP_W-1:0]      rem_reg;
    logic [cbfd_pkg::DLT_W-1:0]        q_reg;

    logic [cbfd_pkg::CLAMP_W:0]        rs;
    logic [cbfd_pkg::CLAMP_W:0]        diff;
    logic                              ge;

    always_comb begin
        rs   = {rem_reg, num_reg[cbfd_pkg::NUM_W-1]};
        ge   = (rs >= {1'b0, dvs_reg});
        diff = rs - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= cbfd_pkg::DCNT_W'(cbfd_pkg::NUM_W - 1);
                // half the divisor added to the numerator rounds half up
                num_reg  <= (cbfd_pkg::NUM_W'(1) << (cbfd_pkg::NUM_W - 1))
                          | cbfd_pkg::NUM_W'(divisor >> 1);
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                q_reg    <= '0;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[cbfd_pkg::CLAMP_W-1:0] : rs[cbfd_pkg::CLAMP_W-1:0];
                q_reg   <= {q_reg[cbfd_pkg::DLT_W-2:0], ge};
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

[hw/rtl/cubic_bezier_forward_diff_raster.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_forward_diff_raster
// rasterizes one cubic bezier curve into its run of distinct integer points
// ----------------------------------------------------------------------------
// One curve (four control points) is taken per input beat; s_tready is high
// only while the block is idle. The step count runs from 1 to 63. Most of the
// setup goes to the bit-serial square root (four perimeter distances, with the
// edge components squared on the shared multiplier first) and the step-size
// divider; the shared multiplier then forms the forward differences, and the
// walk produces one candidate point per cycle while the output side does not
// stall. Points equal to the one before are dropped; tlast marks the final
// point of a curve. tuser flags a curve whose step count was saturated.
`default_nettype none

module cubic_bezier_forward_diff_raster (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // start_x, start_y, first_ctrl_x, first_ctrl_y,
    // second_ctrl_x, second_ctrl_y, end_x, end_y
    input  wire logic [cbfd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // point_x, point_y
    output logic      [cbfd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                     m_tlast,
    // steps_clamped
    output logic                                     m_tuser
);

    localparam int CB = cbfd_pkg::COORD_BITS;
    localparam int MW = cbfd_pkg::MA_W;
    localparam int PW = cbfd_pkg::PROD_W;
    localparam int DW = cbfd_pkg::D_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQA, ST_SQB, ST_ROOT, ST_DIV, ST_MUL, ST_INIT, ST_WALK, ST_FLUSH
    } state_t;

    typedef enum logic [3:0] {
        OP_D2_LO, OP_D2_HI, OP_D3_LO, OP_D3_HI,
        OP_T1X, OP_T1Y, OP_T2X, OP_T2Y, OP_T3X, OP_T3Y
    } op_t;

    state_t                              state_reg;
    op_t                                 op_reg;
    logic [CB-1:0]                       cx_reg [4];
    logic [CB-1:0]                       cy_reg [4];
    logic [1:0]                          dist_reg;
    logic [cbfd_pkg::FACT_W-1:0]         fsum_reg;
    logic [cbfd_pkg::CLAMP_W-1:0]        fact_reg;
    logic                                clamp_reg;
    logic [cbfd_pkg::DLT_W-1:0]          delta_reg;
    logic [cbfd_pkg::DLT_W-1:0]          dl2_reg;
    logic [cbfd_pkg::DLT_W-1:0]          dl3_reg;
    logic signed [PW-1:0]                acc_reg;
    logic signed [PW-1:0]                t1_reg [2];
    logic signed [PW-1:0]                t2_reg [2];
    logic signed [PW-1:0]                t3_reg [2];
    logic signed [DW-1:0]                d1_reg [2];
    logic signed [DW-1:0]                d2_reg [2];
    logic signed [DW-1:0]                d3_reg [2];
    logic signed [DW-1:0]                pos_reg [2];
    logic [cbfd_pkg::STEP_W-1:0]         k_reg;
    logic [CB-1:0]                       pend_x_reg;
    logic [CB-1:0]                       pend_y_reg;
    logic                                pend_v_reg;
    logic [CB-1:0]                       out_x_reg;
    logic [CB-1:0]                       out_y_reg;
    logic                                out_last_reg;
    logic                                out_user_reg;
    logic                                m_tvalid_reg;

    // units
    logic                                root_start;
    logic [cbfd_pkg::SQ_W-1:0]           radicand;
    logic [cbfd_pkg::ROOT_W-1:0]         root;
    logic                                root_done;
    logic                                div_start;
    logic [cbfd_pkg::CLAMP_W-1:0]        fact_c;
    logic                                clamp_c;
    logic [cbfd_pkg::DLT_W-1:0]          quotient;
    logic                                div_done;

    // datapath
    logic [1:0]                          nxt;
    logic signed [CB:0]                  dx;
    logic signed [CB:0]                  dy;
    logic [CB-1:0]                       adx;
    logic [CB-1:0]                       ady;
    logic signed [MW-1:0]                coef1 [2];
    logic signed [MW-1:0]                coef2 [2];
    logic signed [MW-1:0]                coef3 [2];
    logic signed [MW-1:0]                mul_a;
    logic [cbfd_pkg::DLT_W-1:0]          mul_b;
    logic signed [PW-1:0]                prod;
    logic [cbfd_pkg::RND_W-1:0]          full;
    logic [cbfd_pkg::DLT_W-1:0]          rnd;
    logic [cbfd_pkg::FACT_W-1:0]         fsum_add;
    logic [cbfd_pkg::STEP_W-1:0]         n_steps;
    logic [CB-1:0]                       px;
    logic [CB-1:0]                       py;
    logic                                out_free;
    logic                                differ;
    logic                                step_go;
    logic                                push;
    logic                                out_load;

    function automatic logic [CB-1:0] to_pix(input logic signed [DW-1:0] p);
        logic signed [DW-1:0] v;
        v = (p + $signed(DW'(1) << (cbfd_pkg::FRAC_BITS - 1))) >>> cbfd_pkg::FRAC_BITS;
        if (v < 0) begin
            return '0;
        end else if (v > $signed(DW'({CB{1'b1}}))) begin
            return {CB{1'b1}};
        end
        return v[CB-1:0];
    endfunction

    function automatic logic signed [DW-1:0] ext(input logic signed [PW-1:0] t);
        return DW'(t);
    endfunction

    cbfd_root u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (radicand),
        .root     (root),
        .done     (root_done)
    );

    cbfd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (fact_c),
        .quotient (quotient),
        .done     (div_done)
    );

    // perimeter edges and curve coefficients
    always_comb begin
        logic signed [MW-1:0] se, p1e, p2e, ee, t, u, w;
        nxt = dist_reg + 2'd1;
        dx  = $signed({1'b0, cx_reg[nxt]}) - $signed({1'b0, cx_reg[dist_reg]});
        dy  = $signed({1'b0, cy_reg[nxt]}) - $signed({1'b0, cy_reg[dist_reg]});
        adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
        ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];
        for (int ax = 0; ax < 2; ax++) begin
            se  = $signed(MW'(ax == 0 ? cx_reg[0] : cy_reg[0]));
            p1e = $signed(MW'(ax == 0 ? cx_reg[1] : cy_reg[1]));
            p2e = $signed(MW'(ax == 0 ? cx_reg[2] : cy_reg[2]));
            ee  = $signed(MW'(ax == 0 ? cx_reg[3] : cy_reg[3]));
            t   = p1e - se;
            u   = se + p2e - (p1e <<< 1);
            w   = p1e - p2e;
            coef1[ax] = t + (t <<< 1);
            coef2[ax] = u + (u <<< 1);
            coef3[ax] = ee - se + w + (w <<< 1);
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQA: begin
                mul_a = $signed(MW'(adx));
                mul_b = cbfd_pkg::DLT_W'(adx);
            end
            ST_SQB: begin
                mul_a = $signed(MW'(ady));
                mul_b = cbfd_pkg::DLT_W'(ady);
            end
            ST_MUL: begin
                mul_b = delta_reg;
                case (op_reg)
                    OP_D2_LO: mul_a = $signed(MW'(delta_reg[cbfd_pkg::LO_W-1:0]));
                    OP_D2_HI: mul_a = $signed(MW'(delta_reg[cbfd_pkg::DLT_W-1:cbfd_pkg::LO_W]));
                    OP_D3_LO: mul_a = $signed(MW'(dl2_reg[cbfd_pkg::LO_W-1:0]));
                    OP_D3_HI: mul_a = $signed(MW'(dl2_reg[cbfd_pkg::DLT_W-1:cbfd_pkg::LO_W]));
                    OP_T1X:   mul_a = coef1[0];
                    OP_T1Y:   mul_a = coef1[1];
                    OP_T2X: begin
                        mul_a = coef2[0];
                        mul_b = dl2_reg;
                    end
                    OP_T2Y: begin
                        mul_a = coef2[1];
                        mul_b = dl2_reg;
                    end
                    OP_T3X: begin
                        mul_a = coef3[0];
                        mul_b = dl3_reg;
                    end
                    OP_T3Y: begin
                        mul_a = coef3[1];
                        mul_b = dl3_reg;
                    end
                    default: mul_a = '0;
                endcase
            end
            default: mul_a = '0;
        endcase
        prod = PW'(mul_a) * $signed(PW'(mul_b));
        // high partial product joins the low one, rounded half up to Q.32
        full = (cbfd_pkg::RND_W'($unsigned(prod)) << cbfd_pkg::LO_W)
             + cbfd_pkg::RND_W'($unsigned(acc_reg))
             + (cbfd_pkg::RND_W'(1) << (cbfd_pkg::Q_FRAC - 1));
        rnd  = full[cbfd_pkg::Q_FRAC +: cbfd_pkg::DLT_W];
    end

    // unit starts and factor clamp
    always_comb begin
        root_start = (state_reg == ST_SQB);
        radicand   = cbfd_pkg::SQ_W'($unsigned(acc_reg + prod));
        fsum_add   = fsum_reg + cbfd_pkg::FACT_W'(root);
        clamp_c    = (fsum_add > cbfd_pkg::FACT_W'(cbfd_pkg::FACT_CAP));
        if (clamp_c) begin
            fact_c = cbfd_pkg::FACT_CAP;
        end else if (fsum_add < cbfd_pkg::FACT_W'(cbfd_pkg::FACT_ONE)) begin
            fact_c = cbfd_pkg::FACT_ONE;
        end else begin
            fact_c = fsum_add[cbfd_pkg::CLAMP_W-1:0];
        end
        div_start = (state_reg == ST_ROOT) && root_done && (dist_reg == 2'd3);
    end

    // walk step decisions
    always_comb begin
        n_steps  = fact_reg[cbfd_pkg::CLAMP_W-1 -: cbfd_pkg::STEP_W];
        px       = to_pix(pos_reg[0]);
        py       = to_pix(pos_reg[1]);
        out_free = !m_tvalid_reg || m_tready;
        differ   = (px != pend_x_reg) || (py != pend_y_reg);
        step_go  = !pend_v_reg || !differ || out_free;
        push     = pend_v_reg && differ && out_free;
        // a new output beat is loaded this cycle
        out_load = ((state_reg == ST_WALK) && push)
                 || ((state_reg == ST_FLUSH) && out_free);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            pend_v_reg   <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        for (int i = 0; i < 4; i++) begin
                            cx_reg[i] <= s_tdata[(2 * i) * CB +: CB];
                            cy_reg[i] <= s_tdata[(2 * i + 1) * CB +: CB];
                        end
                        dist_reg  <= 2'd0;
                        fsum_reg  <= '0;
                        state_reg <= ST_SQA;
                    end
                end
                ST_SQA: begin
                    acc_reg   <= prod;
                    state_reg <= ST_SQB;
                end
                ST_SQB: begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (root_done) begin
                        fsum_reg <= fsum_add;
                        if (dist_reg == 2'd3) begin
                            fact_reg  <= fact_c;
                            clamp_reg <= clamp_c;
                            state_reg <= ST_DIV;
                        end else begin
                            dist_reg  <= dist_reg + 2'd1;
                            state_reg <= ST_SQA;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        delta_reg <= quotient;
                        op_reg    <= OP_D2_LO;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    op_reg <= op_t'(op_reg + 4'd1);
                    case (op_reg)
                        OP_D2_LO: acc_reg   <= prod;
                        OP_D2_HI: dl2_reg   <= rnd;
                        OP_D3_LO: acc_reg   <= prod;
                        OP_D3_HI: dl3_reg   <= rnd;
                        OP_T1X:   t1_reg[0] <= prod;
                        OP_T1Y:   t1_reg[1] <= prod;
                        OP_T2X:   t2_reg[0] <= prod;
                        OP_T2Y:   t2_reg[1] <= prod;
                        OP_T3X:   t3_reg[0] <= prod;
                        OP_T3Y: begin
                            t3_reg[1] <= prod;
                            state_reg <= ST_INIT;
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                ST_INIT: begin
                    for (int ax = 0; ax < 2; ax++) begin
                        d1_reg[ax] <= ext(t3_reg[ax]) + ext(t2_reg[ax]) + ext(t1_reg[ax]);
                        d2_reg[ax] <= (ext(t3_reg[ax]) <<< 2) + (ext(t3_reg[ax]) <<< 1)
                                    + (ext(t2_reg[ax]) <<< 1);
                        d3_reg[ax] <= (ext(t3_reg[ax]) <<< 2) + (ext(t3_reg[ax]) <<< 1);
                    end
                    pos_reg[0] <= $signed(DW'(cx_reg[0]) << cbfd_pkg::FRAC_BITS);
                    pos_reg[1] <= $signed(DW'(cy_reg[0]) << cbfd_pkg::FRAC_BITS);
                    k_reg      <= '0;
                    pend_v_reg <= 1'b0;
                    state_reg  <= ST_WALK;
                end
                ST_WALK: begin
                    if (step_go) begin
                        pend_x_reg <= px;
                        pend_y_reg <= py;
                        pend_v_reg <= 1'b1;
                        if (push) begin
                            out_x_reg    <= pend_x_reg;
                            out_y_reg    <= pend_y_reg;
                            out_last_reg <= 1'b0;
                            out_user_reg <= clamp_reg;
                        end
                        if (k_reg == n_steps) begin
                            state_reg <= ST_FLUSH;
                        end else begin
                            for (int ax = 0; ax < 2; ax++) begin
                                pos_reg[ax] <= pos_reg[ax]
                                    + ((d1_reg[ax]
                                        + $signed(DW'(1) << (cbfd_pkg::Q_FRAC
                                                             - cbfd_pkg::FRAC_BITS - 1)))
                                       >>> (cbfd_pkg::Q_FRAC - cbfd_pkg::FRAC_BITS));
                                d1_reg[ax] <= d1_reg[ax] + d2_reg[ax];
                                d2_reg[ax] <= d2_reg[ax] + d3_reg[ax];
                            end
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                ST_FLUSH: begin
                    // the held point is the last of the run
                    if (out_free) begin
                        out_x_reg    <= pend_x_reg;
                        out_y_reg    <= pend_y_reg;
                        out_last_reg <= 1'b1;
                        out_user_reg <= clamp_reg;
                        pend_v_reg   <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = cbfd_pkg::OUT_TDATA_W'({out_y_reg, out_x_reg});
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

`include "cubic_bezier_forward_diff_raster_assert.svh"

    `CBFD_ASSERT_NOW(a_accept_no_pending, s_tvalid && s_tready, !pend_v_reg)
    `CBFD_ASSERT_NOW(a_walk_in_range, state_reg == ST_WALK, k_reg <= n_steps)
    `CBFD_ASSERT_NOW(a_clamp_at_cap, state_reg == ST_WALK && clamp_reg,
                     fact_reg == cbfd_pkg::FACT_CAP)
    `CBFD_ASSERT_NEXT(a_flush_ends_run, state_reg == ST_FLUSH && out_free,
                      m_tvalid && m_tlast && state_reg == ST_IDLE)

endmodule

`default_nettype wire
